// File: rtl/core/brw_pkg.sv
// Package for the bounded root window with undo.
// Entry type, cell commands, sequencer states and mode codes. No dependencies.
package brw_pkg;

    localparam int WINDOW_DEPTH_DEF = 64;
    localparam int RETAIN_DEPTH_DEF = 64;
    localparam int HEIGHT_W         = 32;
    localparam int ROOT_W           = 256;
    localparam int COUNT_W          = 7;

    localparam logic [1:0] MODE_RECORD   = 2'd0;
    localparam logic [1:0] MODE_QUERY    = 2'd1;
    localparam logic [1:0] MODE_ROLLBACK = 2'd2;

    typedef struct packed {
        logic [HEIGHT_W-1:0] height;
        logic [ROOT_W-1:0]   root;   // word0 in the top bits
    } brw_entry_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_PREV,
        CELL_NEXT,
        CELL_LOAD
    } brw_cell_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RECORD,
        ST_QUERY,
        ST_POP,
        ST_REFILL,
        ST_DONE
    } brw_state_t;

endpackage

// File: rtl/core/brw_cell.sv
// One storage cell of the window or retained chain.
// Depends on brw_pkg for the entry type and cell commands.
module brw_cell
    import brw_pkg::*;
(
    input  logic         clk,
    input  brw_cell_op_t op,
    input  brw_entry_t   prev,
    input  brw_entry_t   next,
    input  brw_entry_t   load,
    output brw_entry_t   q
);

    brw_entry_t q_reg;
    brw_entry_t q_next;

    always_comb
    begin
        unique case (op)
            CELL_HOLD: q_next = q_reg;
            CELL_PREV: q_next = prev;
            CELL_NEXT: q_next = next;
            CELL_LOAD: q_next = load;
            default:   q_next = q_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

// File: rtl/core/bounded_root_window_with_undo_unit.sv
// Top level of the bounded root window with undo.
// Depends on brw_pkg and brw_cell.
//
// Window and retained store are each a chain of cells, newest entry in cell 0.
// Record shifts the chain towards the old end, the entry falling off a full window
// entering retained cell 0; when cell 0 already holds the same height, only cell 0
// is overwritten. Query rotates the window once round, one cell a cycle, comparing
// cell 0 with the root. Rollback pops one newest entry a cycle while its height is
// above the cut, then takes one retained entry a cycle (inserted at the old end of
// the window or discarded when not older than the window front). Unused mode 3
// goes straight to the result. One beat is worked on at a time; a finished result
// waits in the output register while the next beat is taken in. Counts are
// reported in 7 bits.
module bounded_root_window_with_undo_unit
    import brw_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int RETAIN_DEPTH = RETAIN_DEPTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [287:0] s_tdata,   // height[31:0], root_word0..3 [95:32]..[287:224]
    input  logic [1:0]   s_tuser,   // mode[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [15:0]  m_tdata    // found[0], replaced[1], window_count[8:2],
                                    // retained_count[15:9]
);

    localparam int CW  = $clog2(WINDOW_DEPTH + 1);
    localparam int RCW = $clog2(RETAIN_DEPTH + 1);
    localparam int KW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FH_IDX = (WINDOW_DEPTH > 1) ? WINDOW_DEPTH - 2 : 0;

    brw_state_t state_reg, state_next;

    logic [1:0]     mode_reg;
    brw_entry_t     req_reg;
    logic [CW-1:0]  win_fill_reg, win_fill_next;
    logic [RCW-1:0] ret_fill_reg, ret_fill_next;
    logic [HEIGHT_W-1:0] front_h_reg, front_h_next;
    logic [KW-1:0]  k_reg, k_next;
    logic           found_reg, found_next;
    logic           replaced_reg, replaced_next;
    logic           out_valid_reg, out_valid_next;
    logic [15:0]    out_data_reg, out_data_next;

    brw_entry_t win_q [WINDOW_DEPTH];
    brw_entry_t ret_q [RETAIN_DEPTH];

    brw_cell_op_t win_common, ret_common;
    logic         win_load_en, win_head_only;

    logic accept;
    logic rec_match, win_full, win_empty, ret_empty;
    logic pop_go, refill_go, refill_discard;
    logic out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign win_full  = (win_fill_reg == CW'(WINDOW_DEPTH));
    assign win_empty = (win_fill_reg == '0);
    assign ret_empty = (ret_fill_reg == '0);
    assign rec_match = !win_empty && (win_q[0].height == req_reg.height);
    assign pop_go    = !win_empty && (win_q[0].height > req_reg.height);
    assign refill_go = !win_full && !ret_empty;
    assign refill_discard = !win_empty && (ret_q[0].height >= front_h_reg);
    assign out_free  = !out_valid_reg || m_tready;

    // window chain
    for (genvar i = 0; i < WINDOW_DEPTH; i++)
    begin : g_win
        brw_entry_t   prev_e, next_e;
        brw_cell_op_t op;

        if (i == 0)
        begin : g_head
            assign prev_e = req_reg;
        end
        else
        begin : g_body
            assign prev_e = win_q[i-1];
        end

        if (i == WINDOW_DEPTH - 1)
        begin : g_tail
            assign next_e = win_q[0];   // wrap for the query rotation
        end
        else
        begin : g_mid
            assign next_e = win_q[i+1];
        end

        always_comb
        begin
            if (win_load_en && (win_fill_reg == CW'(i)))
                op = CELL_LOAD;
            else if (win_head_only)
                op = (i == 0) ? CELL_PREV : CELL_HOLD;
            else
                op = win_common;
        end

        brw_cell u_cell (
            .clk  (clk),
            .op   (op),
            .prev (prev_e),
            .next (next_e),
            .load (ret_q[0]),
            .q    (win_q[i])
        );
    end

    // retained chain
    for (genvar j = 0; j < RETAIN_DEPTH; j++)
    begin : g_ret
        brw_entry_t prev_e, next_e;

        if (j == 0)
        begin : g_head
            assign prev_e = win_q[WINDOW_DEPTH-1];
        end
        else
        begin : g_body
            assign prev_e = ret_q[j-1];
        end

        if (j == RETAIN_DEPTH - 1)
        begin : g_tail
            assign next_e = ret_q[j];
        end
        else
        begin : g_mid
            assign next_e = ret_q[j+1];
        end

        brw_cell u_cell (
            .clk  (clk),
            .op   (ret_common),
            .prev (prev_e),
            .next (next_e),
            .load (prev_e),
            .q    (ret_q[j])
        );
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == MODE_RECORD)
                        state_next = ST_RECORD;
                    else if (s_tuser == MODE_QUERY)
                        state_next = ST_QUERY;
                    else if (s_tuser == MODE_ROLLBACK)
                        state_next = ST_POP;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_RECORD: state_next = ST_DONE;
            ST_QUERY:
            begin
                if (k_reg == KW'(WINDOW_DEPTH - 1))
                    state_next = ST_DONE;
            end
            ST_POP:
            begin
                if (!pop_go)
                    state_next = ST_REFILL;
            end
            ST_REFILL:
            begin
                if (!refill_go)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath controls and counters
    always_comb
    begin
        win_common     = CELL_HOLD;
        ret_common     = CELL_HOLD;
        win_load_en    = 1'b0;
        win_head_only  = 1'b0;
        win_fill_next  = win_fill_reg;
        ret_fill_next  = ret_fill_reg;
        front_h_next   = front_h_reg;
        k_next         = k_reg;
        found_next     = found_reg;
        replaced_next  = replaced_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                k_next        = '0;
                found_next    = 1'b0;
                replaced_next = 1'b0;
            end
            ST_RECORD:
            begin
                if (rec_match)
                begin
                    win_head_only = 1'b1;
                    replaced_next = 1'b1;
                end
                else
                begin
                    win_common = CELL_PREV;
                    if (win_full)
                    begin
                        ret_common   = CELL_PREV;
                        front_h_next = (WINDOW_DEPTH > 1) ? win_q[FH_IDX].height
                                                          : req_reg.height;
                        if (ret_fill_reg != RCW'(RETAIN_DEPTH))
                            ret_fill_next = ret_fill_reg + RCW'(1);
                    end
                    else
                    begin
                        if (win_empty)
                            front_h_next = req_reg.height;
                        win_fill_next = win_fill_reg + CW'(1);
                    end
                end
            end
            ST_QUERY:
            begin
                win_common = CELL_NEXT;
                k_next     = k_reg + KW'(1);
                if ((CW'(k_reg) < win_fill_reg) && (win_q[0].root == req_reg.root))
                    found_next = 1'b1;
            end
            ST_POP:
            begin
                if (pop_go)
                begin
                    win_common    = CELL_NEXT;
                    win_fill_next = win_fill_reg - CW'(1);
                end
            end
            ST_REFILL:
            begin
                if (refill_go)
                begin
                    ret_common    = CELL_NEXT;
                    ret_fill_next = ret_fill_reg - RCW'(1);
                    if (!refill_discard)
                    begin
                        win_load_en   = 1'b1;
                        front_h_next  = ret_q[0].height;
                        win_fill_next = win_fill_reg + CW'(1);
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {COUNT_W'(ret_fill_reg), COUNT_W'(win_fill_reg),
                                      replaced_reg, found_reg};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            win_fill_reg  <= '0;
            ret_fill_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            win_fill_reg  <= win_fill_next;
            ret_fill_reg  <= ret_fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= s_tuser;
            req_reg  <= {s_tdata[31:0], s_tdata[95:32], s_tdata[159:96],
                         s_tdata[223:160], s_tdata[287:224]};
        end
        front_h_reg  <= front_h_next;
        k_reg        <= k_next;
        found_reg    <= found_next;
        replaced_reg <= replaced_next;
        out_data_reg <= out_data_next;
    end

    // found only ever comes from a query
    a_found_query: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && found_reg) |-> (mode_reg == MODE_QUERY))
        else $error("found set outside a query");

    a_win_bound: assert property (@(posedge clk) disable iff (!rst_n)
        win_fill_reg <= CW'(WINDOW_DEPTH))
        else $error("window fill beyond depth");

    a_ret_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ret_fill_reg <= RCW'(RETAIN_DEPTH))
        else $error("retained fill beyond depth");

    a_overwrite_keeps_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RECORD && rec_match) |=> $stable(win_fill_reg))
        else $error("overwrite changed window fill");

endmodule
